// File: design/nfsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_pkg
// Shared constants, codes and types of the next-fit slot allocator.
// ----------------------------------------------------------------------------
package nfsa_pkg;

   // Pool geometry. The occupancy map is kept as words of WORD_W bits.
   localparam int SLOTS   = 1024;
   localparam int WORD_W  = 32;
   localparam int WORDS   = SLOTS / WORD_W;
   localparam int WADDR_W = $clog2(WORDS);
   localparam int BIT_W   = $clog2(WORD_W);
   localparam int STEP_W  = WADDR_W + 1;

   // Field widths.
   localparam int ID_W     = 10;
   localparam int LIM_W    = 11;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOT_LIMIT = 3'd0;

   localparam logic [LIM_W-1:0] LIMIT_RESET = 11'd1024;
   localparam logic [LIM_W-1:0] SLOTS_LIM   = LIM_W'(SLOTS);

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_CLAIM_ANY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLAIM_ID  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FREE_ID   = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DONE
   } state_type;

   // Write request into the occupancy map.
   typedef struct packed {
      logic               en;
      logic [WADDR_W-1:0] addr;
      logic [WORD_W-1:0]  data;
   } occ_wr_type;

endpackage

// File: design/nfsa_occ_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_occ_mem
// Occupancy map: one word memory with a registered read port, plus one valid
// bit per word so that a clear empties the whole map at once.
// ----------------------------------------------------------------------------
module nfsa_occ_mem import nfsa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic [WADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0]  rd_data,
   input  occ_wr_type         wr
);

   logic [WORD_W-1:0] mem_ff [WORDS];
   logic [WORDS-1:0]  row_valid_ff;
   logic [WORDS-1:0]  row_valid_in;
   logic [WORD_W-1:0] rd_word_ff;
   logic              rd_valid_ff;

   always_comb begin
      row_valid_in = row_valid_ff;
      if (clear) begin
         row_valid_in = '0;
      end else if (wr.en) begin
         row_valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_word_ff  <= mem_ff[rd_addr];
      rd_valid_ff <= row_valid_ff[rd_addr];
   end

   // A word that has not been written since the last clear reads as all empty.
   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

// File: design/next_fit_slot_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_slot_allocator_core
// Next-fit slot allocator over a pool of 1024 slots with an APB register port.
// ----------------------------------------------------------------------------
// The block takes one request at a time and answers each with one result beat.
// Claiming a named slot or freeing one goes from the accepted request beat
// through ST_EVAL to ST_DONE, where the result is loaded. A slot id beyond the
// limit, an undefined mode, a next-fit claim on a full pool or any claim with
// a zero limit skips ST_EVAL. A next-fit claim reads the occupancy map one
// 32-bit word per cycle, starting at the word of the current position and
// wrapping at the slot limit, until it finds a free slot or has read every
// word in use and the first word once more. A result beat that is still
// waiting holds the next result back, and the block takes no new request until
// that result is loaded. Writing slot_limit empties the map at once through
// per-word valid bits; there is no clearing pass after reset.
module next_fit_slot_allocator_core import nfsa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [9:0] slot_id, rest zero
   input  logic [1:0]            req_tuser,   // [1:0] mode
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [9:0] granted_slot, [20:10] free_count
   output logic [1:0]            rsp_tuser,   // [1:0] status
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   state_type state_ff, state_in;

   logic [LIM_W-1:0]    limit_ff, limit_in;
   logic [ID_W-1:0]     next_pos_ff, next_pos_in;
   logic [LIM_W-1:0]    empty_ff, empty_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [WADDR_W-1:0]  word_ff, word_in;
   logic [BIT_W-1:0]    start_bit_ff, start_bit_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ID_W-1:0]     res_slot_ff, res_slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [LIM_W-1:0]    rsp_free_ff, rsp_free_in;

   logic               csr_wr;
   logic               map_clear;
   logic [WADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0]  rd_data;
   occ_wr_type         occ_wr;

   logic [LIM_W-1:0]   eff_lim;
   logic [LIM_W-1:0]   new_lim;
   logic [LIM_W-1:0]   lim_m1;
   logic [WADDR_W-1:0] last_word;
   logic [WADDR_W-1:0] next_word;
   logic [BIT_W-1:0]   rem_bits;
   logic [STEP_W-1:0]  last_step;
   logic [WORD_W-1:0]  ones;
   logic [WORD_W-1:0]  range_mask;
   logic [WORD_W-1:0]  scan_mask;
   logic [WORD_W-1:0]  word_free;
   logic               hit_any;
   logic [BIT_W-1:0]   hit_bit;
   logic [ID_W-1:0]    hit_slot;
   logic [BIT_W-1:0]   id_bit;
   logic [WORD_W-1:0]  id_onehot;
   logic               id_taken;
   logic [ID_W-1:0]    adv_base;
   logic [LIM_W-1:0]   adv_sum;
   logic [ID_W-1:0]    adv_pos;
   logic [ID_W-1:0]    req_id;
   logic [MODE_W-1:0]  req_mode;

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == CSR_SLOT_LIMIT);
   assign csr_prdata = (csr_paddr == CSR_SLOT_LIMIT) ?
                       {{(CSR_DATA_W-LIM_W){1'b0}}, limit_ff} : '0;
   assign new_lim    = (csr_pwdata[LIM_W-1:0] > SLOTS_LIM) ? SLOTS_LIM
                                                           : csr_pwdata[LIM_W-1:0];
   assign map_clear  = csr_wr;

   // ------------------------------------------------------------------------
   // Geometry of the slots in use
   // ------------------------------------------------------------------------
   assign eff_lim   = (limit_ff > SLOTS_LIM) ? SLOTS_LIM : limit_ff;
   assign lim_m1    = eff_lim - LIM_W'(1);
   assign last_word = lim_m1[BIT_W +: WADDR_W];
   assign rem_bits  = eff_lim[BIT_W-1:0];
   assign last_step = {1'b0, last_word} + STEP_W'(1);
   assign next_word = (word_ff == last_word) ? '0 : word_ff + WADDR_W'(1);
   assign ones      = '1;

   always_comb begin
      if (word_ff != last_word || rem_bits == '0) begin
         range_mask = ones;
      end else begin
         range_mask = ~(ones << rem_bits);
      end
   end

   // The first word is scanned from the start position up, the word after
   // wrapping all the way round only below it.
   always_comb begin
      if (step_ff == '0) begin
         scan_mask = range_mask & (ones << start_bit_ff);
      end else if (step_ff == last_step) begin
         scan_mask = range_mask & ~(ones << start_bit_ff);
      end else begin
         scan_mask = range_mask;
      end
   end

   assign word_free = ~rd_data & scan_mask;
   assign hit_any   = |word_free;

   always_comb begin
      hit_bit = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (word_free[i]) begin
            hit_bit = BIT_W'(i);
         end
      end
   end

   assign hit_slot  = {word_ff, hit_bit};
   assign id_bit    = id_ff[BIT_W-1:0];
   assign id_onehot = {{(WORD_W-1){1'b0}}, 1'b1} << id_bit;
   assign id_taken  = rd_data[id_bit];

   // Shared position advance for both kinds of claim.
   assign adv_base = (mode_ff == MODE_CLAIM_ANY) ? hit_slot : id_ff;
   assign adv_sum  = {1'b0, adv_base} + LIM_W'(1);
   assign adv_pos  = (adv_sum >= eff_lim) ? '0 : adv_sum[ID_W-1:0];

   assign req_id   = req_tdata[ID_W-1:0];
   assign req_mode = req_tuser[MODE_W-1:0];

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      limit_in      = limit_ff;
      next_pos_in   = next_pos_ff;
      empty_in      = empty_ff;
      mode_in       = mode_ff;
      id_in         = id_ff;
      word_in       = word_ff;
      start_bit_in  = start_bit_ff;
      step_in       = step_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_free_in   = rsp_free_ff;
      rd_addr       = word_ff;
      occ_wr.en     = 1'b0;
      occ_wr.addr   = word_ff;
      occ_wr.data   = rd_data;
      req_tready    = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in       = req_mode;
               id_in         = req_id;
               step_in       = '0;
               res_slot_in   = '0;
               res_status_in = STATUS_BUSY;
               case (req_mode)
                  MODE_CLAIM_ANY: begin
                     word_in      = next_pos_ff[BIT_W +: WADDR_W];
                     start_bit_in = next_pos_ff[BIT_W-1:0];
                     rd_addr      = next_pos_ff[BIT_W +: WADDR_W];
                     if (eff_lim == '0 || empty_ff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_EVAL;
                     end
                  end
                  MODE_CLAIM_ID, MODE_FREE_ID: begin
                     word_in = req_id[BIT_W +: WADDR_W];
                     rd_addr = req_id[BIT_W +: WADDR_W];
                     if ({1'b0, req_id} >= eff_lim) begin
                        res_status_in = STATUS_RANGE;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_EVAL;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_EVAL: begin
            case (mode_ff)
               MODE_CLAIM_ANY: begin
                  if (hit_any) begin
                     occ_wr.en     = 1'b1;
                     occ_wr.data   = rd_data | ({{(WORD_W-1){1'b0}}, 1'b1} << hit_bit);
                     empty_in      = empty_ff - LIM_W'(1);
                     next_pos_in   = adv_pos;
                     res_status_in = STATUS_OK;
                     res_slot_in   = hit_slot;
                     state_in      = ST_DONE;
                  end else if (step_ff == last_step) begin
                     state_in = ST_DONE;
                  end else begin
                     step_in = step_ff + STEP_W'(1);
                     word_in = next_word;
                     rd_addr = next_word;
                  end
               end
               MODE_CLAIM_ID: begin
                  if (!id_taken) begin
                     occ_wr.en     = 1'b1;
                     occ_wr.data   = rd_data | id_onehot;
                     empty_in      = empty_ff - LIM_W'(1);
                     next_pos_in   = adv_pos;
                     res_status_in = STATUS_OK;
                     res_slot_in   = id_ff;
                  end
                  state_in = ST_DONE;
               end
               MODE_FREE_ID: begin
                  if (id_taken) begin
                     occ_wr.en   = 1'b1;
                     occ_wr.data = rd_data & ~id_onehot;
                     if (empty_ff < eff_lim) begin
                        empty_in = empty_ff + LIM_W'(1);
                     end
                  end
                  res_status_in = STATUS_OK;
                  res_slot_in   = id_ff;
                  state_in      = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_free_in   = empty_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The user must write registers only while the block is idle; the block does not enforce it.
      if (csr_wr) begin
         limit_in    = csr_pwdata[LIM_W-1:0];
         next_pos_in = '0;
         empty_in    = new_lim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         next_pos_ff  <= '0;
         empty_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         next_pos_ff  <= next_pos_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      id_ff         <= id_in;
      word_ff       <= word_in;
      start_bit_ff  <= start_bit_in;
      step_ff       <= step_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_free_ff   <= rsp_free_in;
   end

   nfsa_occ_mem u_occ_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (map_clear),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (occ_wr)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_free_ff, rsp_slot_ff};

endmodule

// File: tb/tb_next_fit_slot_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_next_fit_slot_allocator_core
// Self-checking bench for the next-fit slot allocator.
// ----------------------------------------------------------------------------
// Requests go in on the req_ stream and each one is predicted at the beat that
// accepts it by a local model of the occupancy map, the next-fit cursor and
// the free count. Every rsp_ beat is checked field by field against the oldest
// prediction. Directed tests cover the reset pool, a zero limit, a full pool
// and a saturated limit. Random phases then run mixed claims and frees over
// several slot limits. The sender works in bursts and the receiver stalls on
// a rotating pattern.
module tb_next_fit_slot_allocator_core;
   import nfsa_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     slot;
      logic [LIM_W-1:0]    free_count;
   } alloc_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;   // [9:0] slot_id, rest zero
   logic [1:0]            req_tuser;   // [1:0] mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [23:0]           rsp_tdata;   // [9:0] granted_slot, [20:10] free_count
   logic [1:0]            rsp_tuser;   // [1:0] status
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   next_fit_slot_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Allocator model state.
   logic [LIM_W-1:0] limit_q;
   bit               slot_taken [SLOTS];
   int unsigned      cursor;
   int unsigned      empty_slots;

   alloc_result_type pending_results [$];
   int unsigned   failures;
   int unsigned   requests_sent;
   int unsigned   results_checked;
   int unsigned   granted_count;
   int unsigned   busy_count;
   int unsigned   range_count;
   int unsigned   burst_left;
   int unsigned   stall_cycle;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int unsigned usable_slots();
      return (limit_q > SLOTS) ? SLOTS : limit_q;
   endfunction

   function automatic void empty_pool();
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      cursor      = 0;
      empty_slots = usable_slots();
   endfunction

   function automatic int unsigned step_slot(int unsigned pos, int unsigned lim);
      return (pos + 1 >= lim) ? 0 : pos + 1;
   endfunction

   function automatic alloc_result_type predict_allocation(input logic [MODE_W-1:0] mode,
                                                           input logic [ID_W-1:0] id);
      alloc_result_type r;
      int unsigned   lim;
      int unsigned   pos;
      lim      = usable_slots();
      r.status = STATUS_BUSY;
      r.slot   = '0;
      if (cursor >= lim) cursor = 0;
      case (mode)
         MODE_CLAIM_ANY: begin
            pos = cursor;
            for (int i = 0; i < lim; i++) begin
               if (!slot_taken[pos]) begin
                  slot_taken[pos] = 1'b1;
                  r.slot   = ID_W'(pos);
                  r.status = STATUS_OK;
                  if (empty_slots > 0) empty_slots--;
                  cursor = step_slot(pos, lim);
                  break;
               end
               pos = step_slot(pos, lim);
            end
         end
         MODE_CLAIM_ID: begin
            if (id >= lim) begin
               r.status = STATUS_RANGE;
            end else if (!slot_taken[id]) begin
               slot_taken[id] = 1'b1;
               r.slot   = id;
               r.status = STATUS_OK;
               if (empty_slots > 0) empty_slots--;
               cursor = step_slot(id, lim);
            end
         end
         MODE_FREE_ID: begin
            if (id >= lim) begin
               r.status = STATUS_RANGE;
            end else begin
               // Freeing a slot that is already empty keeps the count as it is.
               if (slot_taken[id]) begin
                  slot_taken[id] = 1'b0;
                  if (empty_slots < lim) empty_slots++;
               end
               r.slot   = id;
               r.status = STATUS_OK;
            end
         end
         default: ;
      endcase
      r.free_count = LIM_W'(empty_slots);
      return r;
   endfunction

   // Sends one request beat. Called at a rising edge; returns at the edge
   // that accepted the beat, with valid still high.
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'b0, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_allocation(mode, id));
      requests_sent++;
   endtask

   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_slot_limit(input logic [LIM_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_SLOT_LIMIT;
      csr_pwdata  <= {{(CSR_DATA_W-LIM_W){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      limit_q = value;
      empty_pool();
   endtask

   // Receiver: checks each result beat and rotates its stall behavior through four patterns.
   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_cycle <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
               $error("result beat with no request outstanding");
               failures++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  failures++;
               end
               if (rsp_tdata[9:0] !== want.slot) begin
                  $error("granted_slot: expected %0d, got %0d", want.slot, rsp_tdata[9:0]);
                  failures++;
               end
               if (rsp_tdata[20:10] !== want.free_count) begin
                  $error("free_count: expected %0d, got %0d",
                         want.free_count, rsp_tdata[20:10]);
                  failures++;
               end
               case (want.status)
                  STATUS_OK:    granted_count++;
                  STATUS_BUSY:  busy_count++;
                  default:      range_count++;
               endcase
            end
         end
         stall_cycle <= stall_cycle + 1;
         case ((stall_cycle / 97) % 4)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= $urandom_range(0, 1);
            2:       rsp_tready <= ($urandom_range(0, 4) == 0);
            default: rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic test_default_pool();
      send_request(MODE_CLAIM_ANY, 10'd0);
      send_request(MODE_CLAIM_ID, 10'd1023);
      send_request(MODE_CLAIM_ANY, 10'd1023);
      send_request(MODE_CLAIM_ID, 10'd0);
      send_request(MODE_FREE_ID, 10'd1023);
      send_request(MODE_FREE_ID, 10'd1023);
      send_request(MODE_UNDEFINED, 10'd1023);
      send_request(MODE_CLAIM_ID, 10'd512);
      send_request(MODE_FREE_ID, 10'd341);
      wait_until_idle();
   endtask

   task automatic test_zero_limit();
      write_slot_limit(11'd0);
      send_request(MODE_CLAIM_ANY, 10'd0);
      send_request(MODE_CLAIM_ID, 10'd0);
      send_request(MODE_FREE_ID, 10'd1023);
      wait_until_idle();
   endtask

   task automatic test_full_pool();
      write_slot_limit(11'd2);
      send_request(MODE_CLAIM_ANY, 10'd0);
      send_request(MODE_CLAIM_ANY, 10'd0);
      send_request(MODE_CLAIM_ANY, 10'd0);
      send_request(MODE_CLAIM_ID, 10'd2);
      send_request(MODE_FREE_ID, 10'd1);
      send_request(MODE_CLAIM_ANY, 10'd0);
      wait_until_idle();
   endtask

   task automatic test_saturated_limit();
      write_slot_limit(11'd2047);
      send_request(MODE_CLAIM_ID, 10'd1023);
      send_request(MODE_CLAIM_ANY, 10'd0);
      send_request(MODE_FREE_ID, 10'd1023);
      wait_until_idle();
   endtask

   function automatic logic [ID_W-1:0] random_slot(int unsigned lim);
      if (lim == 0 || $urandom_range(0, 99) < 12) return ID_W'($urandom_range(0, 1023));
      return ID_W'($urandom_range(0, lim - 1));
   endfunction

   // Picks a slot that is in use if there is one, so that most frees really release something.
   function automatic logic [ID_W-1:0] taken_slot(int unsigned lim);
      int unsigned start;
      int unsigned idx;
      if (lim == 0) return random_slot(lim);
      start = $urandom_range(0, lim - 1);
      for (int k = 0; k < lim; k++) begin
         idx = (start + k) % lim;
         if (slot_taken[idx]) return ID_W'(idx);
      end
      return ID_W'(start);
   endfunction

   task automatic test_random_phase(input logic [LIM_W-1:0] limit, input int unsigned count,
                                    input int unsigned claim_pct);
      int unsigned pick;
      int unsigned lim;
      write_slot_limit(limit);
      lim = usable_slots();
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < claim_pct)
            send_request(MODE_CLAIM_ANY, ID_W'($urandom_range(0, 1023)));
         else if (pick < claim_pct + 20)
            send_request(MODE_CLAIM_ID, random_slot(lim));
         else if (pick < 97)
            send_request(MODE_FREE_ID,
                         ($urandom_range(0, 9) < 7) ? taken_slot(lim) : random_slot(lim));
         else
            send_request(MODE_UNDEFINED, ID_W'($urandom_range(0, 1023)));
      end
      wait_until_idle();
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      failures        = 0;
      requests_sent   = 0;
      results_checked = 0;
      granted_count   = 0;
      busy_count      = 0;
      range_count     = 0;
      burst_left      = 0;
      limit_q         = LIMIT_RESET;
      empty_pool();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_pool();
      test_zero_limit();
      test_full_pool();
      test_saturated_limit();
      test_random_phase(11'd37, 90, 55);
      test_random_phase(11'd1024, 90, 45);
      test_random_phase(11'd1, 40, 45);
      test_random_phase(11'd2047, 90, 50);
      test_random_phase(11'd300, 100, 65);
      test_random_phase(11'd8, 80, 45);
      test_random_phase(11'd1024, 110, 40);

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests over limits 1024, 0, 2, 2047, 37, 1, 300 and 8.",
               requests_sent);
      $display("Checked %0d results: %0d granted, %0d busy, %0d out of range.",
               results_checked, granted_count, busy_count, range_count);
      if (failures == 0 && pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: sim.f
design/nfsa_pkg.sv
design/nfsa_occ_mem.sv
design/next_fit_slot_allocator_core.sv
tb/tb_next_fit_slot_allocator_core.sv
